FILE: src/wss_pkg.sv
// ---------------------------------------------------------------------------
// wss_pkg: shared types and constants for the wildcard signature scanner
// Holds the sizing constants, register indices, status codes and the cell
// control struct used between the window and its cells.
// ---------------------------------------------------------------------------
package wss_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int OFFSET_BITS  = 32;
    localparam int LEN_W        = 5;
    localparam int PAT_W        = 8 * MAX_PATTERN;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;

    localparam logic [7:0] WILDCARD = 8'h2A;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    typedef enum logic [1:0] {
        ST_SCANNING  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_REPORTED  = 2'd3
    } status_t;

    // control broadcast to every cell of the window
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic logic [7:0] pattern_byte(input logic [PAT_W-1:0] pat,
                                                input logic [3:0] idx);
        pattern_byte = pat[idx*8 +: 8];
    endfunction

endpackage

FILE: src/wss_cell.sv
// ---------------------------------------------------------------------------
// wss_cell: one window cell
// Holds one window byte, hands it to the next cell, and checks the byte it
// takes in against its expected pattern byte.
// ---------------------------------------------------------------------------
module wss_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  wss_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          shift_in,
    input  logic [7:0]          expected,
    input  logic                in_use,
    output logic [7:0]          win_byte,
    output logic                ok
);
    import wss_pkg::*;

    logic [7:0] win_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_byte_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            win_byte_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            win_byte_reg <= shift_in;
        end
    end

    // check is made on the incoming byte, i.e. the post-shift window
    assign ok       = !in_use || (expected == WILDCARD) || (expected == shift_in);
    assign win_byte = win_byte_reg;

endmodule

FILE: src/wss_window.sv
// ---------------------------------------------------------------------------
// wss_window: sliding byte window as a chain of cells
// Cell 0 takes the new byte; each cell feeds its neighbour. Every cell is
// matched against pattern byte (len-1-k); hit is the AND of all cells.
// ---------------------------------------------------------------------------
module wss_window
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  wss_pkg::cell_ctrl_t         ctrl,
    input  logic [7:0]                  data_in,
    input  logic [wss_pkg::PAT_W-1:0]   pattern,
    input  logic [wss_pkg::LEN_W-1:0]   len,
    output logic                        hit
);
    import wss_pkg::*;

    logic [7:0]             cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic [7:0]       shift_in;
            logic [LEN_W-1:0] pat_idx;
            logic             in_use;

            if (k == 0)
            begin : g_head
                assign shift_in = data_in;
            end
            else
            begin : g_body
                assign shift_in = cell_byte[k-1];
            end

            assign in_use  = (LEN_W'(k) < len);
            assign pat_idx = len - LEN_W'(1) - LEN_W'(k);

            wss_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .shift_in (shift_in),
                .expected (pattern_byte(pattern, pat_idx[3:0])),
                .in_use   (in_use),
                .win_byte (cell_byte[k]),
                .ok       (cell_ok[k])
            );
        end
    endgenerate

    assign hit = &cell_ok;

endmodule

FILE: src/wildcard_signature_scanner_top.sv
// ---------------------------------------------------------------------------
// wildcard_signature_scanner_top: wildcard byte pattern search
// Streams a memory region byte by byte and reports where a wildcard pattern
// first matches.
// ---------------------------------------------------------------------------
// Usage
//   Input beats (s_*): one byte of the region per beat in s_tdata, s_tlast
//   on the final byte. Output beats (m_*): one per input beat, status in
//   m_tuser (scanning / found / not found / already reported), start offset
//   of the match in m_tdata, zero unless status is found.
//   Pattern is set through cfg_we/cfg_index/cfg_data: index 0 pattern bytes
//   0-7, index 1 bytes 8-15, index 2 length (0 is taken as 1, above 16 as
//   16). Byte 0x2A in the pattern matches anything. Write only while idle.
//   Each result is held in the single result register. Throughput: one
//   beat per cycle while m_tready is high; all sixteen window cells
//   compare in parallel in the cycle the byte is taken.
//   Stall: s_tready follows !m_tvalid || m_tready, so a held result blocks
//   new input only while it is itself stalled.
//   Reset: window, offset counter and found flag clear, pattern registers
//   go to zero with length 1. The same scan state clears after every
//   last byte. The offset counter saturates at its maximum.
// ---------------------------------------------------------------------------
module wildcard_signature_scanner_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // last_byte
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // [31:0] match_offset
    output logic [1:0]                         m_tuser,   // [1:0] status
    // configuration write port
    input  logic                               cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wss_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wss_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    // configuration registers
    logic [63:0]      pat_low_reg;
    logic [63:0]      pat_high_reg;
    logic [LEN_W-1:0] pat_len_reg;

    // scan state
    logic [OFFSET_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic                   match_reported_reg, match_reported_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [31:0]            out_offset_reg, out_offset_next;

    logic                   in_fire;
    logic                   hit;
    logic                   saturated;
    logic                   enough;
    logic [LEN_W-1:0]       len_eff;
    logic [OFFSET_BITS-1:0] offset_full;
    cell_ctrl_t             cell_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PAT_LOW)
            begin
                pat_low_reg <= cfg_data;
            end
            if (cfg_index == REG_PAT_HIGH)
            begin
                pat_high_reg <= cfg_data;
            end
            if (cfg_index == REG_PAT_LEN)
            begin
                pat_len_reg <= cfg_data[LEN_W-1:0];
            end
        end
    end

    // effective length: zero acts as one, cap at MAX_PATTERN
    always_comb
    begin
        priority if (pat_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (pat_len_reg > LEN_W'(MAX_PATTERN))
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = pat_len_reg;
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign cell_ctrl.shift = in_fire;
    assign cell_ctrl.clear = in_fire && s_tlast;

    wss_window u_window
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cell_ctrl),
        .data_in (s_tdata),
        .pattern ({pat_high_reg, pat_low_reg}),
        .len     (len_eff),
        .hit     (hit)
    );

    // bytes_seen is the index of the byte being taken
    assign saturated   = (bytes_seen_reg == OFFSET_MAX);
    assign enough      = saturated ||
                         (bytes_seen_reg >= OFFSET_BITS'(len_eff - LEN_W'(1)));
    assign offset_full = saturated ? OFFSET_MAX
                                   : bytes_seen_reg - OFFSET_BITS'(len_eff - LEN_W'(1));

    always_comb
    begin
        bytes_seen_next     = bytes_seen_reg;
        match_reported_next = match_reported_reg;
        out_valid_next      = out_valid_reg;
        out_status_next     = out_status_reg;
        out_offset_next     = out_offset_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            out_valid_next  = 1'b1;
            out_offset_next = '0;
            priority if (match_reported_reg)
            begin
                out_status_next = ST_REPORTED;
            end
            else if (enough && hit)
            begin
                out_status_next     = ST_FOUND;
                out_offset_next     = offset_full[31:0];
                match_reported_next = 1'b1;
            end
            else if (s_tlast)
            begin
                out_status_next = ST_NOT_FOUND;
            end
            else
            begin
                out_status_next = ST_SCANNING;
            end

            if (!saturated)
            begin
                bytes_seen_next = bytes_seen_reg + OFFSET_BITS'(1);
            end

            // region ends: scan state back to reset
            if (s_tlast)
            begin
                bytes_seen_next     = '0;
                match_reported_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg     <= '0;
            match_reported_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            bytes_seen_reg     <= bytes_seen_next;
            match_reported_reg <= match_reported_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_offset_reg;

    // a first match that is not on the last byte latches the found flag
    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !s_tlast && !match_reported_reg && enough && hit)
        |=> match_reported_reg)
        else $error("found flag not set after first match");

    // end of region clears the counter and the found flag
    a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> (bytes_seen_reg == '0 && !match_reported_reg))
        else $error("scan state not cleared after last byte");

    // offset is zero on every beat that is not a match
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_FOUND) |-> (m_tdata == '0))
        else $error("offset non-zero without a match");

endmodule

FILE: tb/sv/tb_wildcard_signature_scanner_top.sv
// ---------------------------------------------------------------------------
// tb_wildcard_signature_scanner_top: self-checking bench for the scanner
// Drives regions of bytes through the input stream, predicts the status and
// match offset of every byte in a scoreboard, and compares each output beat
// in order. Regions mostly carry the configured pattern (sometimes broken)
// inside random data. Both stream sides idle at random, and one long receiver
// hold-off backs the block up into its input.
// ---------------------------------------------------------------------------
module tb_wildcard_signature_scanner_top;

    import wss_pkg::*;

    localparam int CLK_HALF      = 1;
    localparam int RESET_CYCLES  = 3;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int PAT_REG_BYTES = 16;   // bytes held by the two pattern words
    localparam int PRESSURE_HOLD = 250;  // long receiver hold-off, in cycles

    // index 3 decodes to nothing; writes there must leave the pattern alone
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // receiver back-pressure patterns
    typedef enum int {
        RX_ALWAYS,   // never stalls
        RX_COIN,     // ready half of the time
        RX_MOSTLY,   // stalls one cycle in eight
        RX_SPARSE    // ready one cycle in three
    } rx_pattern_e;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } scan_byte_t;

    typedef struct {
        status_t                status;
        logic [OFFSET_BITS-1:0] offset;
    } scan_result_t;

    // -----------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the pattern registers and scan state,
    // works out the status beat for each accepted byte and checks the output
    // beats against those in order.
    // -----------------------------------------------------------------------
    class scan_scoreboard;
        logic [63:0]            pat_low;
        logic [63:0]            pat_high;
        logic [LEN_W-1:0]       pat_len;
        logic [7:0]             window [MAX_PATTERN];
        logic [OFFSET_BITS-1:0] bytes_seen;
        bit                     reported;
        scan_result_t           expected_q [$];
        int                     errors;

        function new();
            pat_low  = '0;
            pat_high = '0;
            pat_len  = 1;
            errors   = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (window[i])
                window[i] = 8'h00;
            bytes_seen = '0;
            reported   = 1'b0;
        endfunction

        // length actually compared: zero counts as one, clipped to the window
        function int eff_len();
            int n;
            n = pat_len;
            if (n == 0)
                n = 1;
            if (n > MAX_PATTERN)
                n = MAX_PATTERN;
            if (n > PAT_REG_BYTES)
                n = PAT_REG_BYTES;
            return n;
        endfunction

        function logic [7:0] pat_byte_at(int i);
            logic [63:0] word;
            word = (i < 8) ? pat_low : pat_high;
            return word[(i % 8) * 8 +: 8];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_PAT_LOW:  pat_low  = val;
                REG_PAT_HIGH: pat_high = val;
                REG_PAT_LEN:  pat_len  = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted input beat -> one expected output beat
        function void note_byte(logic [7:0] data, logic last);
            int                     n;
            bit                     enough;
            bit                     hit;
            logic [7:0]             p;
            logic [OFFSET_BITS-1:0] sat;
            scan_result_t           r;
            n   = eff_len();
            sat = '1;
            for (int i = MAX_PATTERN - 1; i > 0; i--)
                window[i] = window[i - 1];
            window[0] = data;
            // bytes_seen is the index of this byte within the region
            enough = (bytes_seen == sat) || ({32'd0, bytes_seen} + 64'd1 >= 64'(n));
            hit = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                p = pat_byte_at(i);
                if (p != WILDCARD && p != window[n - 1 - i])
                    hit = 1'b0;
            end
            r.status = ST_SCANNING;
            r.offset = '0;
            if (reported)
                r.status = ST_REPORTED;
            else if (enough && hit)
            begin
                r.status = ST_FOUND;
                reported = 1'b1;
                r.offset = (bytes_seen == sat) ? sat
                                               : bytes_seen - OFFSET_BITS'(n - 1);
            end
            else if (last)
                r.status = ST_NOT_FOUND;
            if (bytes_seen != sat)
                bytes_seen++;
            expected_q.push_back(r);
            if (last)
                clear_scan();
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] off);
            scan_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output beat: status %0d offset %0d", st, off);
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status || off !== e.offset)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("beat mismatch: expected status %s offset %0d, got status %0d offset %0d",
                             e.status.name(), e.offset, st, off);
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT and its stimulus signals
    // -----------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    scan_scoreboard sb;
    scan_byte_t     byte_q [$];   // bytes still to be offered this phase
    int             hold_cycles;  // receiver hold-off request, counted down by rx
    bit             tx_gaps;      // sender leaves gaps between bursts
    int             cycle_count;

    wildcard_signature_scanner_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // watchdog: a hung handshake or a lost beat ends up here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_wildcard_signature_scanner_top failed");
            $finish;
        end
    end

    // monitor: both sides sampled at the edge, before any update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
        end
    end

    // receiver: runs its own stall patterns in segments of random length;
    // a hold-off request from the main flow overrides them
    initial
    begin : rx
        int          seg_left;
        rx_pattern_e mode;
        seg_left = 0;
        mode     = RX_ALWAYS;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = rx_pattern_e'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                    default:   m_tready <= (seg_left % 3 == 0);
                endcase
            end
        end
    end

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------

    // config writes hold cfg_we high across back-to-back writes; the caller
    // lowers it once the set is done
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [63:0] len_word, input logic [63:0] junk);
        write_reg(REG_PAT_LOW, lo);
        write_reg(REG_PAT_HIGH, hi);
        write_reg(REG_UNUSED, junk);
        write_reg(REG_PAT_LEN, len_word);
        cfg_we <= 1'b0;
    endtask

    // offers byte_q in bursts; valid stays high straight through a burst
    task automatic drive_bytes();
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 24);
        while (byte_q.size() != 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= byte_q[0].data;
            s_tlast  <= byte_q[0].last;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            void'(byte_q.pop_front());
            burst_left--;
            if (byte_q.size() == 0)
                s_tvalid <= 1'b0;
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = tx_gaps ? $urandom_range(0, 8) : 0;
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // send the queued bytes and wait for every status beat to come back;
    // the final byte is noted by the monitor at its accepting edge, so step
    // on past that edge before looking at the scoreboard queue
    task automatic run_bytes();
        drive_bytes();
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void push_byte(input logic [7:0] data, input logic last);
        scan_byte_t b;
        b.data = data;
        b.last = last;
        byte_q.push_back(b);
    endfunction

    // pattern word: each byte a wildcard one time in four, plus the extremes
    function automatic logic [63:0] rand_pattern_word();
        logic [63:0] w;
        case ($urandom_range(0, 9))
            0:       w = '1;
            1:       w = '0;
            default:
            begin
                for (int i = 0; i < 8; i++)
                    w[i * 8 +: 8] = ($urandom_range(0, 3) == 0) ? WILDCARD
                                                                 : 8'($urandom_range(0, 255));
            end
        endcase
        return w;
    endfunction

    // one region: mostly the current pattern planted in random bytes,
    // sometimes with one byte flipped, sometimes plain noise
    function automatic void add_region();
        int         len;
        int         kind;
        int         n;
        int         start;
        int         k;
        bit         narrow;
        logic [7:0] p;
        logic [7:0] region [];
        len    = sb.eff_len();
        kind   = $urandom_range(0, 9);
        n      = $urandom_range(1, 2 * len + 12);
        narrow = ($urandom_range(0, 3) == 0);
        if (kind <= 7 && n < len)
            n = len + $urandom_range(0, 4);
        region = new[n];
        // a narrow alphabet of pattern bytes makes near misses and overlaps
        for (int i = 0; i < n; i++)
            region[i] = narrow ? sb.pat_byte_at($urandom_range(0, len - 1))
                               : 8'($urandom_range(0, 255));
        if (kind <= 7)
        begin
            // a third of planted matches end exactly on the last byte
            start = ($urandom_range(0, 2) == 0) ? n - len : $urandom_range(0, n - len);
            for (int i = 0; i < len; i++)
            begin
                p = sb.pat_byte_at(i);
                region[start + i] = (p == WILDCARD) ? 8'($urandom_range(0, 255)) : p;
            end
            if (kind >= 6)
            begin
                k = start + $urandom_range(0, len - 1);
                region[k] = region[k] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        for (int i = 0; i < n; i++)
            push_byte(region[i], i == n - 1);
    endfunction

    // -----------------------------------------------------------------------
    // Main flow
    // -----------------------------------------------------------------------
    initial
    begin : main
        int          random_items;
        int          phase;
        int          target;
        logic [63:0] len_word;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_cycles = 0;
        tx_gaps     = 1'b1;
        cycle_count = 0;
        sb          = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern is a single 0x00: scan, found at offset 1, then
        // already reported (also on the last byte), then a fresh region
        // that ends without a match
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b1);
        run_bytes();

        // length field 0 with junk above it acts as 1; a lone wildcard
        // matches a one-byte region on its last byte
        set_pattern(64'h0000_0000_0000_002A, '1, 64'hFFFF_FFFF_FFFF_FFE0, '1);
        push_byte(8'hAB, 1'b1);
        run_bytes();

        // length 31 clips to 16; pattern of zeros ending in a wildcard would
        // already hit the cleared window, so the first 15 bytes must not match
        set_pattern('0, 64'h2A00_0000_0000_0000, 64'd31, '0);
        for (int i = 0; i < 15; i++)
            push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        run_bytes();

        // random phases: new settings each time, regions with planted patterns
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            len_word = {$urandom(), $urandom()};
            if ($urandom_range(0, 1) == 0)
                len_word[63:LEN_W] = '0;
            case ($urandom_range(0, 7))
                0:       len_word[LEN_W-1:0] = 5'd0;
                1:       len_word[LEN_W-1:0] = 5'd1;
                2:       len_word[LEN_W-1:0] = 5'd16;
                3:       len_word[LEN_W-1:0] = 5'($urandom_range(17, 31));
                default: len_word[LEN_W-1:0] = 5'($urandom_range(1, 16));
            endcase
            set_pattern(rand_pattern_word(), rand_pattern_word(), len_word,
                        {$urandom(), $urandom()});

            tx_gaps = ($urandom_range(0, 3) != 0);
            target  = $urandom_range(20, 120);
            if (phase == 2)
            begin
                // pressure: receiver holds off while the sender keeps offering
                tx_gaps     = 1'b0;
                hold_cycles = PRESSURE_HOLD;
                target      = 300;
            end
            else if ($urandom_range(0, 9) == 0)
                hold_cycles = $urandom_range(30, 120);

            while (byte_q.size() < target)
                add_region();
            // now and then leave the region open so the next settings
            // land mid-region
            if ($urandom_range(0, 3) == 0)
                byte_q[byte_q.size() - 1].last = 1'b0;

            random_items += byte_q.size();
            run_bytes();
            phase++;
        end

        // everything back; give stray beats a chance to show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_wildcard_signature_scanner_top passed");
        else
            $display("tb_wildcard_signature_scanner_top failed");
        $finish;
    end

endmodule
